/* sv/rml_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rml_pkg: shared types and constants for the region majority label block
// Default sizes, action codes and the vote tracker control bundle.
// ----------------------------------------------------------------------------
package rml_pkg;

  localparam int RML_NUM_REGIONS = 256;
  localparam int RML_NUM_LABELS  = 256;
  localparam int RML_COUNT_BITS  = 20;

  localparam logic [7:0] RML_INVALID_RESET = 8'd255;

  localparam int RML_OUT_COUNT_BITS = 20;

  // input transaction kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // control from the sequencer to the vote tracker
  typedef struct packed {
    logic       init;        // start a new vote
    logic       step;        // offer one count to the compare unit
    logic [7:0] init_label;  // label reported when nothing beats zero
    logic [7:0] step_label;  // label of the offered count
  } rml_trk_ctl_t;

endpackage : rml_pkg
`default_nettype wire

/* sv/rml_vote_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rml_vote_tracker: running maximum over one region's label counts
// Shared compare unit; a later label wins only on a strictly higher count.
// ----------------------------------------------------------------------------
module rml_vote_tracker
  import rml_pkg::*;
#(
  parameter int COUNT_BITS = RML_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire rml_trk_ctl_t          ctl,
  input  wire logic [COUNT_BITS-1:0] step_count,
  output logic      [7:0]            best_label,
  output logic      [COUNT_BITS-1:0] best_count
);

  logic [7:0]            best_label_r, best_label_nxt;
  logic [COUNT_BITS-1:0] best_count_r, best_count_nxt;

  always_comb begin
    best_label_nxt = best_label_r;
    best_count_nxt = best_count_r;
    if (ctl.init) begin
      best_label_nxt = ctl.init_label;
      best_count_nxt = '0;
    end else if (ctl.step && (step_count > best_count_r)) begin
      best_label_nxt = ctl.step_label;
      best_count_nxt = step_count;
    end
  end

  always_ff @(posedge clk) begin
    best_label_r <= best_label_nxt;
    best_count_r <= best_count_nxt;
  end

  assign best_label = best_label_r;
  assign best_count = best_count_r;

endmodule : rml_vote_tracker
`default_nettype wire

/* sv/region_majority_label_top.sv */
// Pixel transaction: the count is read at accept and written back in S_PIX_WR, with in_stall high.
// Query transaction: S_SCAN reads the row through the single count memory port, then S_DONE
//   loads the vote into the output register and out_valid rises; the next transaction is taken
//   only after that, and also waits while a stalled earlier result holds the output register.
// Reset: synchronous active-low rst_n, then a clearing pass over all NUM_REGIONS * 2^ceil(log2
//   NUM_LABELS) entries (65536 at defaults) with in_stall high; cfg writes are taken meanwhile.
`default_nettype none
// ----------------------------------------------------------------------------
// region_majority_label_top: per-region label histogram with majority vote
// Pixels bump a saturating counter at (region, label). A query scans the
// region's row in ascending label order, reports the most frequent label
// (smallest on ties, invalid label if empty) and zeroes the row as it goes.
// ----------------------------------------------------------------------------
module region_majority_label_top
  import rml_pkg::*;
#(
  parameter int NUM_REGIONS = RML_NUM_REGIONS,
  parameter int NUM_LABELS  = RML_NUM_LABELS,
  parameter int COUNT_BITS  = RML_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_region_index,
  input  wire logic [7:0]  in_label,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_queried_region,
  output logic      [7:0]  out_majority_label,
  output logic      [19:0] out_majority_count,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_invalid_label
);

  // Address layout: {region, label}; the label part is padded to a power of two
  // so no multiply is needed. Padding entries are never counted but get cleared.
  localparam int RB        = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int LB        = (NUM_LABELS  > 1) ? $clog2(NUM_LABELS)  : 1;
  localparam int AW        = RB + LB;
  localparam int MEM_DEPTH = NUM_REGIONS << LB;

  localparam logic [12:0]   NR_LIM    = 13'(NUM_REGIONS);
  localparam logic [8:0]    NL_LIM    = 9'(NUM_LABELS);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_DEPTH - 1);
  localparam logic [LB-1:0] LAB_LAST  = LB'(NUM_LABELS - 1);

  // One-hot sequencer states
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,  // post-reset sweep of the count memory
    S_IDLE   = 6'b000010,  // ready for a transaction
    S_PIX_WR = 6'b000100,  // write back the incremented count
    S_SCAN   = 6'b001000,  // one label per cycle: compare, zero, read next
    S_DONE   = 6'b010000   // hand the vote to the output register
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------------
  // Configuration: invalid label register, always writable
  // ---------------------------------------------------------------------------
  logic [7:0] inv_label_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_label_r <= RML_INVALID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_label_r <= cfg_invalid_label;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic              in_accept;
  logic              reg_ok;
  logic              lab_ok;
  logic [RB+7:0]     reg_ext;
  logic [LB+7:0]     lab_ext;
  logic [AW-1:0]     in_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign reg_ok    = (13'(in_region_index) < NR_LIM);
  assign lab_ok    = (9'(in_label) < NL_LIM);
  assign reg_ext   = (RB+8)'(in_region_index);
  assign lab_ext   = (LB+8)'(in_label);

  // a query starts its scan at label zero of the row
  assign in_addr = (in_action == ACT_QUERY) ? {reg_ext[RB-1:0], {LB{1'b0}}}
                                            : {reg_ext[RB-1:0], lab_ext[LB-1:0]};

  // Item context
  logic [AW-1:0] addr_r;
  logic          pix_ok_r;
  logic [7:0]    region_r;
  logic [LB-1:0] lab_idx_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r   <= in_addr;
      pix_ok_r <= reg_ok && lab_ok;
      region_r <= in_region_index;
    end
  end

  // label counter for the scan; entry lab_idx_r sits in rd_data_r
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lab_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      lab_idx_r <= lab_idx_r + LB'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Count memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] count_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] sat_inc;
  logic [AW-1:0]         clr_addr_r;

  // saturating increment for pixel updates
  assign sat_inc = (&rd_data_r) ? rd_data_r : rd_data_r + COUNT_BITS'(1);

  always_comb begin
    rd_addr = in_addr;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
      end
      S_PIX_WR: begin
        wr_en   = pix_ok_r;
        wr_data = sat_inc;
      end
      S_SCAN: begin
        // zero the entry just voted on, fetch the next one
        wr_en   = 1'b1;
        wr_addr = {addr_r[AW-1:LB], lab_idx_r};
        rd_addr = {addr_r[AW-1:LB], lab_idx_r + LB'(1)};
      end
      default: begin
        rd_addr = in_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= count_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == S_CLEAR) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Vote tracker (shared compare unit)
  // ---------------------------------------------------------------------------
  rml_trk_ctl_t          trk_ctl;
  logic [7:0]            best_label;
  logic [COUNT_BITS-1:0] best_count;

  assign trk_ctl.init       = in_accept && (in_action == ACT_QUERY);
  assign trk_ctl.step       = (state_r == S_SCAN);
  assign trk_ctl.init_label = inv_label_r;
  assign trk_ctl.step_label = 8'(lab_idx_r);

  rml_vote_tracker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_vote (
    .clk        (clk),
    .ctl        (trk_ctl),
    .step_count (rd_data_r),
    .best_label (best_label),
    .best_count (best_count)
  );

  // ---------------------------------------------------------------------------
  // Output register: frees the sequencer while a result waits
  // ---------------------------------------------------------------------------
  logic                     out_valid_r;
  logic                     out_load;
  logic [7:0]               out_region_r;
  logic [7:0]               out_label_r;
  logic [19:0]              out_count_r;
  logic [COUNT_BITS+19:0]   count_ext;

  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign count_ext = (COUNT_BITS+20)'(best_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_region_r <= region_r;
      out_label_r  <= best_label;
      out_count_r  <= count_ext[19:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_queried_region = out_region_r;
  assign out_majority_label = out_label_r;
  assign out_majority_count = out_count_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == ADDR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_action == ACT_PIXEL) state_nxt = S_PIX_WR;
          else if (reg_ok)            state_nxt = S_SCAN;
          else                        state_nxt = S_DONE;  // region out of range
        end
      end
      S_PIX_WR: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (lab_idx_r == LAB_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : region_majority_label_top
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for region_majority_label_top
// Streams pixel and query transactions into the block and keeps its own
// per-region label histogram. Each query result is compared field by field
// against the vote predicted from that histogram. A directed table comes
// first, then random bursts of pixels closed by queries, run under several
// invalid-label settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import rml_pkg::*;

  localparam int CNT_MAX   = (1 << RML_COUNT_BITS) - 1;
  localparam int N_DIR     = 22;
  localparam int PHASE_LEN = 258;   // random transactions per idling phase
  localparam int SETTLE    = 16;    // quiet cycles: covers a pixel in flight

  // one expected query result
  typedef struct packed {
    bit [7:0]  region;
    bit [7:0]  label;
    bit [19:0] count;
  } vote_t;

  // directed row: a transaction plus, where obvious, its typed-in answer
  typedef struct packed {
    bit        act;
    bit [7:0]  rgn;
    bit [7:0]  lab;
    bit        typed;
    bit [7:0]  t_label;
    bit [19:0] t_count;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // empty regions right after reset, both ends of the index range
    '{ACT_QUERY, 8'd0,   8'd0,   1'b1, RML_INVALID_RESET, 20'd0},
    '{ACT_QUERY, 8'd255, 8'd255, 1'b1, RML_INVALID_RESET, 20'd0},
    // extreme labels; 255 wins 2:1
    '{ACT_PIXEL, 8'd0,   8'd0,   1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd0,   8'd255, 1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd0,   8'd255, 1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd0,   8'd17,  1'b1, 8'd255, 20'd2},
    // the query cleared the row
    '{ACT_QUERY, 8'd0,   8'd0,   1'b1, RML_INVALID_RESET, 20'd0},
    // tie: smaller label wins even though it arrived later
    '{ACT_PIXEL, 8'd255, 8'd7,   1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd255, 8'd3,   1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd255, 8'd0,   1'b1, 8'd3, 20'd1},
    // winner is label 0, same value as nothing beating zero
    '{ACT_PIXEL, 8'd1,   8'd0,   1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd1,   8'd200, 1'b1, 8'd0, 20'd1},
    // alternating bit patterns, interleaved regions
    '{ACT_PIXEL, 8'd170, 8'd85,  1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd85,  8'd170, 1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd170, 8'd85,  1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd170, 8'd170, 1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd170, 8'd0,   1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd85,  8'd0,   1'b0, 8'd0, 20'd0},
    // later larger count beats an earlier smaller label
    '{ACT_PIXEL, 8'd2,   8'd128, 1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd2,   8'd127, 1'b0, 8'd0, 20'd0},
    '{ACT_PIXEL, 8'd2,   8'd128, 1'b0, 8'd0, 20'd0},
    '{ACT_QUERY, 8'd2,   8'd0,   1'b0, 8'd0, 20'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_PIXEL;
  logic [7:0]  in_region_index = 8'd0;
  logic [7:0]  in_label = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_queried_region;
  logic [7:0]  out_majority_label;
  logic [19:0] out_majority_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_invalid_label = 8'd0;

  // predictor state: histogram and the invalid-label register
  bit [RML_COUNT_BITS-1:0] hist [RML_NUM_REGIONS][RML_NUM_LABELS];
  bit [7:0]                invalid_lbl = RML_INVALID_RESET;
  vote_t                   pending_votes [$];

  // idling knobs, percent of cycles
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  int unsigned n_errors   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_pixels   = 0;
  int unsigned n_queries  = 0;
  int unsigned n_results  = 0;
  int unsigned n_nonempty = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  region_majority_label_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_region_index   (in_region_index),
    .in_label          (in_label),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_queried_region(out_queried_region),
    .out_majority_label(out_majority_label),
    .out_majority_count(out_majority_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_invalid_label (cfg_invalid_label)
  );

  // --------------------------------------------------------------------------
  // Histogram predictor
  // --------------------------------------------------------------------------

  // saturating bump; out-of-range region or label is dropped
  function automatic void tally_pixel(bit [7:0] rgn, bit [7:0] lab);
    if (rgn < RML_NUM_REGIONS && lab < RML_NUM_LABELS) begin
      if (hist[rgn][lab] < CNT_MAX)
        hist[rgn][lab] = hist[rgn][lab] + RML_COUNT_BITS'(1);
    end
  endfunction

  // scan upward, strictly greater replaces (smallest label on ties), then clear
  function automatic vote_t tally_query(bit [7:0] rgn);
    vote_t       v;
    int unsigned best;
    best     = 0;
    v.region = rgn;
    v.label  = invalid_lbl;
    if (rgn < RML_NUM_REGIONS) begin
      for (int k = 0; k < RML_NUM_LABELS; k++) begin
        if (hist[rgn][k] > best) begin
          best    = 32'(hist[rgn][k]);
          v.label = k[7:0];
        end
        hist[rgn][k] = '0;
      end
    end
    v.count = best[19:0];
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR %0t: %0s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic check_vote();
    vote_t want;
    if (pending_votes.size() == 0) begin
      report_mismatch("unexpected result, region", 32'(out_queried_region), 0);
      return;
    end
    want = pending_votes.pop_front();
    n_results++;
    if (want.count != 0)
      n_nonempty++;
    if (out_queried_region !== want.region)
      report_mismatch("queried_region", 32'(out_queried_region), 32'(want.region));
    if (out_majority_label !== want.label)
      report_mismatch("majority_label", 32'(out_majority_label), 32'(want.label));
    if (out_majority_count !== want.count)
      report_mismatch("majority_count", 32'(out_majority_count), 32'(want.count));
  endtask

  // out_stall is read before its own update, so this sees the value that
  // held at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_vote();
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Drives one transaction and returns at the edge that took it. Valid stays
  // high into the next call unless that call opens a gap, so each step sees
  // one assignment to in_valid.
  task automatic send_item(bit act, bit [7:0] rgn, bit [7:0] lab,
                           bit typed = 1'b0, bit [7:0] t_label = 8'd0,
                           bit [19:0] t_count = 20'd0);
    int unsigned gap;
    vote_t       v;
    gap = 0;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
      gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_region_index <= rgn;
    in_label        <= lab;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (act == ACT_PIXEL) begin
      n_pixels++;
      tally_pixel(rgn, lab);
    end else begin
      n_queries++;
      v = tally_query(rgn);
      if (typed) begin
        v.label = t_label;
        v.count = t_count;
      end
      pending_votes.push_back(v);
    end
  endtask

  // waits for the block to drain, then writes the invalid label
  task automatic write_invalid(bit [7:0] val);
    in_valid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_invalid_label <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    invalid_lbl = val;
  endtask

  // Mostly bursts of pixels into one region over a few labels, closed by a
  // query, so ties and real majorities show up. The rest is loose pixels and
  // queries of arbitrary (usually empty) regions.
  task automatic run_phase(int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned nlab;
    int unsigned len;
    bit [7:0]    hot [8];
    bit [7:0]    labs [4];
    bit [7:0]    rgn;
    start = n_sent;
    foreach (hot[i]) hot[i] = 8'($urandom_range(255));
    while (n_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        rgn  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : hot[$urandom_range(7)];
        nlab = $urandom_range(1, 4);
        foreach (labs[i]) labs[i] = 8'($urandom_range(255));
        len  = $urandom_range(1, 12);
        repeat (len) send_item(ACT_PIXEL, rgn, labs[$urandom_range(nlab - 1)]);
        if ($urandom_range(4) != 0)
          send_item(ACT_QUERY, rgn, 8'($urandom_range(255)));
      end else if (pick < 90) begin
        send_item(ACT_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        send_item(ACT_QUERY, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit [7:0] cfg_vals [4];
    int unsigned idle_set  [4];
    int unsigned stall_set [4];
    // extremes first, then two random settings
    cfg_vals[0] = 8'd0;
    cfg_vals[1] = 8'd255;
    cfg_vals[2] = 8'($urandom_range(1, 254));
    cfg_vals[3] = 8'($urandom_range(255));
    // no idling, sender idle, receiver stalling, both
    idle_set  = '{0, 61, 0, 26};
    stall_set = '{0, 0, 61, 26};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, invalid label still at its reset value; the block's
    // clearing pass holds in_stall until it is done
    for (int i = 0; i < N_DIR; i++)
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].rgn, DIR_ROWS[i].lab,
                DIR_ROWS[i].typed, DIR_ROWS[i].t_label, DIR_ROWS[i].t_count);

    for (int p = 0; p < 4; p++) begin
      write_invalid(cfg_vals[p]);
      sender_idle_pct = idle_set[p];
      recv_stall_pct  = stall_set[p];
      run_phase(PHASE_LEN);
    end

    in_valid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d transactions: %0d pixels, %0d queries over 4 idling phases",
             n_sent, n_pixels, n_queries);
    $display("Checked %0d vote results, %0d from non-empty regions, %0d errors",
             n_results, n_nonempty, n_errors);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog: the clearing pass plus a normal run is well under a tenth of this,
  // and an all-query run under the heaviest stalls stays several times below it
  initial begin
    #8000000;
    $display("ERROR: timeout, %0d transactions sent, %0d results pending",
             n_sent, pending_votes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule : testbench
`default_nettype wire
